// ===== design/crc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the compact rational canonicalizer
// no dependencies
package crc_pkg;
  localparam int TupleSlots = 5;
  localparam int SumW       = 11;
  localparam int QW         = 4;
  localparam int QSumW      = 6;
  localparam int RankW      = $clog2(TupleSlots + 1);
  localparam logic [14:0] WholeMax = 15'h3FFF;
  localparam logic [14:0] WholeMin = 15'h4001;
  localparam logic [7:0]  DenBase  = 8'h80;

  typedef struct packed {
    logic [14:0]                             whole;
    logic [TupleSlots-1:0][6:0]              off;
    logic [TupleSlots-1:0][SumW-1:0]         sum;
  } merge_t;

  typedef struct packed {
    logic [14:0]                 whole;
    logic [QSumW-1:0]            qsum;
    logic [TupleSlots-1:0][6:0]  off;
    logic [TupleSlots-1:0][7:0]  rem;
  } div_t;

  typedef struct packed {
    logic [15:0]                  whole_word;
    logic [TupleSlots-1:0][15:0]  tuples;
    logic                         clamped;
  } canon_t;
endpackage

// ===== design/crc_merge.sv =====
`timescale 1ns / 1ps
// stage 1: picks the tuples in use and sums numerators per denominator
// depends on crc_pkg
module crc_merge (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [15:0]                           whole_word_i,
  input  logic [crc_pkg::TupleSlots-1:0][15:0]  tuple_i,
  output crc_pkg::merge_t                       merge_o
);
  import crc_pkg::*;

  merge_t merge_d, merge_q;
  logic [TupleSlots-1:0] used;
  logic [TupleSlots-1:0] lead;
  logic                  ended;

  always_comb begin
    ended = 1'b0;
    for (int j = 0; j < TupleSlots; j++) begin
      used[j] = whole_word_i[15] && !ended;
      ended   = ended || tuple_i[j][7];
    end
    merge_d.whole = whole_word_i[14:0];
    for (int j = 0; j < TupleSlots; j++) begin
      lead[j] = used[j];
      for (int k = 0; k < j; k++) begin
        if (used[k] && tuple_i[k][6:0] == tuple_i[j][6:0]) lead[j] = 1'b0;
      end
      merge_d.off[j] = tuple_i[j][6:0];
      merge_d.sum[j] = '0;
      for (int k = j; k < TupleSlots; k++) begin
        if (lead[j] && used[k] && tuple_i[k][6:0] == tuple_i[j][6:0]) begin
          merge_d.sum[j] = merge_d.sum[j] + SumW'(tuple_i[k][15:8]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) merge_q <= merge_d;
  end

  assign merge_o = merge_q;
endmodule

// ===== design/crc_divide.sv =====
`timescale 1ns / 1ps
// stage 2: splits each merged sum into whole multiples and a remainder
// depends on crc_pkg
module crc_divide (
  input  logic            clk_i,
  input  logic            en_i,
  input  crc_pkg::merge_t merge_i,
  output crc_pkg::div_t   div_o
);
  import crc_pkg::*;

  div_t div_d, div_q;
  logic [SumW:0]  r;
  logic [SumW:0]  dsh;
  logic [QW-1:0]  q;

  always_comb begin
    div_d.whole = merge_i.whole;
    div_d.off   = merge_i.off;
    div_d.qsum  = '0;
    r = '0;
    q = '0;
    dsh = '0;
    for (int j = 0; j < TupleSlots; j++) begin
      r = {1'b0, merge_i.sum[j]};
      for (int b = QW - 1; b >= 0; b--) begin
        dsh = (SumW+1)'({DenBase[7], merge_i.off[j]}) << b;
        q[b] = r >= dsh;
        if (q[b]) r = r - dsh;
      end
      div_d.rem[j] = r[7:0];
      div_d.qsum = div_d.qsum + QSumW'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) div_q <= div_d;
  end

  assign div_o = div_q;
endmodule

// ===== design/crc_sort.sv =====
`timescale 1ns / 1ps
// stage 3: saturates the whole part and orders remainders by denominator
// depends on crc_pkg
module crc_sort (
  input  logic            clk_i,
  input  logic            en_i,
  input  crc_pkg::div_t   div_i,
  output crc_pkg::canon_t canon_o
);
  import crc_pkg::*;

  canon_t canon_d, canon_q;
  logic [TupleSlots-1:0]            nz;
  logic [TupleSlots-1:0][RankW-1:0] rank;
  logic [RankW-1:0]                 cnt;
  logic signed [15:0]               w;

  always_comb begin
    cnt = '0;
    for (int j = 0; j < TupleSlots; j++) begin
      nz[j] = div_i.rem[j] != 8'h00;
      cnt = cnt + RankW'(nz[j]);
    end
    for (int j = 0; j < TupleSlots; j++) begin
      rank[j] = '0;
      for (int k = 0; k < TupleSlots; k++) begin
        if (nz[k] && div_i.off[k] < div_i.off[j]) rank[j] = rank[j] + RankW'(1);
      end
    end
    for (int s = 0; s < TupleSlots; s++) begin
      canon_d.tuples[s] = '0;
      for (int j = 0; j < TupleSlots; j++) begin
        if (nz[j] && rank[j] == RankW'(s)) begin
          canon_d.tuples[s] = {div_i.rem[j], (rank[j] + RankW'(1) == cnt), div_i.off[j]};
        end
      end
    end
    w = {div_i.whole[14], div_i.whole} + 16'(div_i.qsum);
    canon_d.clamped = 1'b0;
    if (w > $signed({1'b0, WholeMax})) begin
      w = {1'b0, WholeMax};
      canon_d.clamped = 1'b1;
    end else if (w < $signed({1'b1, WholeMin})) begin
      w = {1'b1, WholeMin};
      canon_d.clamped = 1'b1;
    end
    canon_d.whole_word = {cnt != '0, w[14:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) canon_q <= canon_d;
  end

  assign canon_o = canon_q;
endmodule

// ===== design/compact_rational_canonicalizer.sv =====
`timescale 1ns / 1ps
// Canonicalizes one compact rational per item through a three-stage pipeline
// (merge, divide, sort/saturate). An item may enter every cycle while the
// output is not stalled; its result passes the merge, divide and sort registers
// before valid_o rises. A stall at the output holds the whole pipeline. Depends
// on crc_pkg, crc_merge, crc_divide, crc_sort.
module compact_rational_canonicalizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [15:0] whole_word_i,
  input  logic [15:0] tuple_word_0_i,
  input  logic [15:0] tuple_word_1_i,
  input  logic [15:0] tuple_word_2_i,
  input  logic [15:0] tuple_word_3_i,
  input  logic [15:0] tuple_word_4_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [15:0] canon_whole_word_o,
  output logic [15:0] canon_tuple_0_o,
  output logic [15:0] canon_tuple_1_o,
  output logic [15:0] canon_tuple_2_o,
  output logic [15:0] canon_tuple_3_o,
  output logic [15:0] canon_tuple_4_o,
  output logic        whole_clamped_o
);
  import crc_pkg::*;

  logic                         en;
  logic [2:0]                   vld_q;
  logic [TupleSlots-1:0][15:0]  tuples;
  merge_t                       merge;
  div_t                         div;
  canon_t                       canon;

  assign en      = !vld_q[2] || ready_i;
  assign ready_o = en;
  assign valid_o = vld_q[2];
  assign tuples  = {tuple_word_4_i, tuple_word_3_i, tuple_word_2_i,
                    tuple_word_1_i, tuple_word_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  crc_merge u_merge (
    .clk_i, .en_i(en), .whole_word_i, .tuple_i(tuples), .merge_o(merge)
  );
  crc_divide u_divide (.clk_i, .en_i(en), .merge_i(merge), .div_o(div));
  crc_sort u_sort (.clk_i, .en_i(en), .div_i(div), .canon_o(canon));

  assign canon_whole_word_o = canon.whole_word;
  assign canon_tuple_0_o    = canon.tuples[0];
  assign canon_tuple_1_o    = canon.tuples[1];
  assign canon_tuple_2_o    = canon.tuples[2];
  assign canon_tuple_3_o    = canon.tuples[3];
  assign canon_tuple_4_o    = canon.tuples[4];
  assign whole_clamped_o    = canon.clamped;
endmodule
